[rtl/core/touch_sample_filter_assert.svh]
// ----------------------------------------------------------------------------
// Touch sample filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_FILTER_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_ASSERT_SVH

// Check a property on every rising edge outside reset
`define TSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next
`define TSF_ASSERT_NEXT(label, ante, cons, msg) \
	`TSF_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/core/tsf_pkg.sv]
// ----------------------------------------------------------------------------
// Touch sample filter package
// Field widths, register indexes, reset values and the orientation codes.
// ----------------------------------------------------------------------------
package tsf_pkg;

	localparam int unsigned ADC_W    = 12;
	localparam int unsigned PRESS_W  = 13;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned IVAL_W   = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [ADC_W-1:0] FULL_SCALE = 12'd4095;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd2;

	// Panel rotation codes
	typedef enum logic [1:0] {
		ORIENT_SWAP_INV_X = 2'd0,
		ORIENT_IDENTITY   = 2'd1,
		ORIENT_SWAP_INV_Y = 2'd2,
		ORIENT_INV_BOTH   = 2'd3
	} orient_t;

	// Reset values
	localparam orient_t            RST_ORIENTATION  = ORIENT_IDENTITY;
	localparam logic [PRESS_W-1:0] RST_PRESS_THRESH = 13'd400;
	localparam logic [IVAL_W-1:0]  RST_MIN_INTERVAL = 8'd3;
	localparam logic [TIME_W-1:0]  RST_LAST_GOOD    = 32'h8000_0000;

	// Three readings of one axis
	typedef struct packed {
		logic [ADC_W-1:0] first;
		logic [ADC_W-1:0] second;
		logic [ADC_W-1:0] third;
	} axis_set_t;

endpackage

[rtl/core/tsf_pair_lane.sv]
// ----------------------------------------------------------------------------
// Touch sample filter axis lane
// Finds the closest pair among three readings and returns its mean.
// ----------------------------------------------------------------------------
module tsf_pair_lane
	import tsf_pkg::*;
(
	input  axis_set_t        readings,
	output logic [ADC_W-1:0] mean
);

	logic [ADC_W-1:0]   d_ab;
	logic [ADC_W-1:0]   d_ac;
	logic [ADC_W-1:0]   d_bc;
	logic [ADC_W-1:0]   op_l;
	logic [ADC_W-1:0]   op_r;
	logic [ADC_W:0]     pair_sum;

	// Form the three distances
	always_comb begin
		d_ab = (readings.first > readings.second) ? readings.first - readings.second
		                                          : readings.second - readings.first;
		d_ac = (readings.first > readings.third)  ? readings.first - readings.third
		                                          : readings.third - readings.first;
		d_bc = (readings.second > readings.third) ? readings.second - readings.third
		                                          : readings.third - readings.second;
	end

	// Pick the closest pair, ties going to first/second, then first/third
	always_comb begin
		if (d_ab <= d_ac && d_ab <= d_bc) begin
			op_l = readings.first;
			op_r = readings.second;
		end else if (d_ac <= d_bc) begin
			op_l = readings.first;
			op_r = readings.third;
		end else begin
			op_l = readings.second;
			op_r = readings.third;
		end
	end

	// Average with truncation
	assign pair_sum = {1'b0, op_l} + {1'b0, op_r};
	assign mean     = pair_sum[ADC_W:1];

endmodule

[rtl/core/tsf_rotate.sv]
// ----------------------------------------------------------------------------
// Touch sample filter lane merge
// Combines the X and Y lane means into panel coordinates by orientation.
// ----------------------------------------------------------------------------
module tsf_rotate
	import tsf_pkg::*;
(
	input  orient_t          orient,
	input  logic [ADC_W-1:0] mean_x,
	input  logic [ADC_W-1:0] mean_y,
	output logic [ADC_W-1:0] rot_x,
	output logic [ADC_W-1:0] rot_y
);

	// Swap and mirror the axes
	always_comb begin
		unique case (orient)
			ORIENT_SWAP_INV_X: begin
				rot_x = FULL_SCALE - mean_y;
				rot_y = mean_x;
			end
			ORIENT_IDENTITY: begin
				rot_x = mean_x;
				rot_y = mean_y;
			end
			ORIENT_SWAP_INV_Y: begin
				rot_x = mean_y;
				rot_y = FULL_SCALE - mean_x;
			end
			default: begin
				rot_x = FULL_SCALE - mean_x;
				rot_y = FULL_SCALE - mean_y;
			end
		endcase
	end

endmodule

[rtl/core/touch_sample_filter.sv]
// ----------------------------------------------------------------------------
// Touch sample filter
// Rate-limited resistive touch filter: best two of three per axis, rotation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample event: a timestamp,
//   two pressure readings and three readings per axis. Each accepted
//   transaction yields exactly one output transaction (out_valid/out_ready)
//   with the sampled flag, touched flag, held position and held pressure.
//   out_valid rises in the cycle after input acceptance. Throughput is one
//   transaction per cycle unless the receiver stalls: the held state is
//   updated in the cycle of acceptance, so the next sample can follow directly.
//   The X and Y lanes find their closest pairs side by side; the merge
//   stage rotates the pair into panel coordinates.
//   A single output register separates the channels; in_ready stays high
//   while that register is empty or being drained, and drops when the
//   receiver stalls with a result pending.
//   Reset clears the output valid flag and loads orientation 1, threshold 400,
//   interval 3 ms, last good time 0x80000000 and zero held values.
//   Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at
//   the next edge; unused indexes are ignored.
// ----------------------------------------------------------------------------
module touch_sample_filter
	import tsf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [ADC_W-1:0]      press_a,
	input  logic [ADC_W-1:0]      press_b,
	input  logic [ADC_W-1:0]      x_first,
	input  logic [ADC_W-1:0]      x_second,
	input  logic [ADC_W-1:0]      x_third,
	input  logic [ADC_W-1:0]      y_first,
	input  logic [ADC_W-1:0]      y_second,
	input  logic [ADC_W-1:0]      y_third,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  sampled,
	output logic                  touched,
	output logic [ADC_W-1:0]      pos_x,
	output logic [ADC_W-1:0]      pos_y,
	output logic [PRESS_W-1:0]    pressure
);

	orient_t              orient_q;
	logic [PRESS_W-1:0]   thresh_q;
	logic [IVAL_W-1:0]    min_ival_q;

	logic [TIME_W-1:0]    last_good_q;
	logic [PRESS_W-1:0]   held_press_q;
	logic [ADC_W-1:0]     held_x_q;
	logic [ADC_W-1:0]     held_y_q;

	logic                 out_valid_q;
	logic                 sampled_q;
	logic                 touched_q;
	logic [ADC_W-1:0]     pos_x_q;
	logic [ADC_W-1:0]     pos_y_q;
	logic [PRESS_W-1:0]   pressure_q;

	logic                 in_fire;
	logic [TIME_W-1:0]    elapsed;
	logic                 pass;
	logic [PRESS_W-1:0]   z_val;
	logic                 light;
	axis_set_t            set_x;
	axis_set_t            set_y;
	logic [ADC_W-1:0]     mean_x;
	logic [ADC_W-1:0]     mean_y;
	logic [ADC_W-1:0]     rot_x;
	logic [ADC_W-1:0]     rot_y;
	logic [PRESS_W-1:0]   nxt_press;
	logic [ADC_W-1:0]     nxt_x;
	logic [ADC_W-1:0]     nxt_y;
	logic [TIME_W-1:0]    nxt_last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q   <= RST_ORIENTATION;
			thresh_q   <= RST_PRESS_THRESH;
			min_ival_q <= RST_MIN_INTERVAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIENTATION:  orient_q   <= orient_t'(cfg_wdata[1:0]);
				REG_PRESS_THRESH: thresh_q   <= cfg_wdata[PRESS_W-1:0];
				REG_MIN_INTERVAL: min_ival_q <= cfg_wdata[IVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept while the output register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Rate limit and pressure
	assign elapsed = now_ms - last_good_q;
	assign pass    = elapsed >= {{(TIME_W-IVAL_W){1'b0}}, min_ival_q};
	assign z_val   = {1'b0, press_a} + {1'b0, FULL_SCALE} - {1'b0, press_b};
	assign light   = z_val < thresh_q;

	// Axis lanes
	assign set_x = '{first: x_first, second: x_second, third: x_third};
	assign set_y = '{first: y_first, second: y_second, third: y_third};

	tsf_pair_lane u_lane_x (
		.readings (set_x),
		.mean     (mean_x)
	);

	tsf_pair_lane u_lane_y (
		.readings (set_y),
		.mean     (mean_y)
	);

	// Merge lanes into panel coordinates
	tsf_rotate u_rotate (
		.orient (orient_q),
		.mean_x (mean_x),
		.mean_y (mean_y),
		.rot_x  (rot_x),
		.rot_y  (rot_y)
	);

	// Next held state
	always_comb begin
		nxt_press = held_press_q;
		nxt_x     = held_x_q;
		nxt_y     = held_y_q;
		nxt_last  = last_good_q;
		if (pass) begin
			if (light) begin
				nxt_press = '0;
			end else begin
				nxt_press = z_val;
				nxt_x     = rot_x;
				nxt_y     = rot_y;
				nxt_last  = now_ms;
			end
		end
	end

	// Held state, advanced on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_good_q  <= RST_LAST_GOOD;
			held_press_q <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
		end else if (in_fire) begin
			last_good_q  <= nxt_last;
			held_press_q <= nxt_press;
			held_x_q     <= nxt_x;
			held_y_q     <= nxt_y;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded on acceptance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sampled_q  <= pass;
			touched_q  <= nxt_press >= thresh_q;
			pos_x_q    <= nxt_x;
			pos_y_q    <= nxt_y;
			pressure_q <= nxt_press;
		end
	end

	assign out_valid = out_valid_q;
	assign sampled   = sampled_q;
	assign touched   = touched_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pressure  = pressure_q;

endmodule

[rtl/core/tsf_checker.sv]
// ----------------------------------------------------------------------------
// Touch sample filter checker
// Port-level assertions on handshakes and held values, bound to the top.
// ----------------------------------------------------------------------------
`include "touch_sample_filter_assert.svh"

module tsf_checker
	import tsf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  sampled,
	input logic                  touched,
	input logic [ADC_W-1:0]      pos_x,
	input logic [ADC_W-1:0]      pos_y,
	input logic [PRESS_W-1:0]    pressure
);

	// Stalled result holds its payload
	`TSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sampled) && $stable(touched) && $stable(pos_x) && $stable(pos_y) && $stable(pressure), "stalled output changed")

	// Empty output register never blocks the input
	`TSF_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with no pending result")

	// Every accepted transaction shows a result in the next cycle
	`TSF_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "accepted sample produced no result")

	// A rate-limited result repeats the previous held values
	`TSF_ASSERT(a_skip_repeats, (out_valid && out_ready) ##1 (out_valid && !sampled) |-> pos_x == $past(pos_x) && pos_y == $past(pos_y) && pressure == $past(pressure), "skipped sample changed held values")

endmodule

bind touch_sample_filter tsf_checker u_tsf_checker (.*);

[verif/touch_sample_filter_test.sv]
// ----------------------------------------------------------------------------
// Touch sample filter testbench
// Sends sample events through the valid/ready input and predicts each result
// with a local model of the rate limit, the pressure threshold, the closest
// pair mean and the panel rotation. Every result is checked field by field
// against the oldest prediction. Directed cases come first, then random
// traffic over several register settings, with random gaps and stalls on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module touch_sample_filter_test
	import tsf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned LONG_HOLD    = 80;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_ITEMS  = 75;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [TIME_W-1:0] now;
		logic [ADC_W-1:0]  za;
		logic [ADC_W-1:0]  zb;
		axis_set_t         xs;
		axis_set_t         ys;
	} sample_t;

	typedef struct {
		logic               sampled;
		logic               touched;
		logic [ADC_W-1:0]   pos_x;
		logic [ADC_W-1:0]   pos_y;
		logic [PRESS_W-1:0] pressure;
	} report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [TIME_W-1:0]     now_ms = '0;
	logic [ADC_W-1:0]      press_a = '0;
	logic [ADC_W-1:0]      press_b = '0;
	logic [ADC_W-1:0]      x_first = '0;
	logic [ADC_W-1:0]      x_second = '0;
	logic [ADC_W-1:0]      x_third = '0;
	logic [ADC_W-1:0]      y_first = '0;
	logic [ADC_W-1:0]      y_second = '0;
	logic [ADC_W-1:0]      y_third = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  sampled;
	logic                  touched;
	logic [ADC_W-1:0]      pos_x;
	logic [ADC_W-1:0]      pos_y;
	logic [PRESS_W-1:0]    pressure;

	// Predictor copy of the registers and held state
	orient_t            cfg_orient = RST_ORIENTATION;
	logic [PRESS_W-1:0] cfg_thresh = RST_PRESS_THRESH;
	logic [IVAL_W-1:0]  cfg_ival   = RST_MIN_INTERVAL;
	logic [TIME_W-1:0]  held_time  = RST_LAST_GOOD;
	logic [PRESS_W-1:0] held_press = '0;
	logic [ADC_W-1:0]   held_x     = '0;
	logic [ADC_W-1:0]   held_y     = '0;

	report_t           pending_reports[$];
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic              no_gaps = 1'b0;
	int unsigned       hold_reqs = 0;
	int unsigned       hold_seen = 0;
	int unsigned       stall_left = 0;

	touch_sample_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.now_ms    (now_ms),
		.press_a   (press_a),
		.press_b   (press_b),
		.x_first   (x_first),
		.x_second  (x_second),
		.x_third   (x_third),
		.y_first   (y_first),
		.y_second  (y_second),
		.y_third   (y_third),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sampled   (sampled),
		.touched   (touched),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pressure  (pressure)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Mean of the two closest readings; ties favor first/second, then first/third
	function automatic logic [ADC_W-1:0] pair_mean(axis_set_t v);
		logic [ADC_W-1:0] d_ab, d_ac, d_bc;
		logic [ADC_W:0]   sum;
		d_ab = (v.first > v.second) ? v.first - v.second : v.second - v.first;
		d_ac = (v.first > v.third) ? v.first - v.third : v.third - v.first;
		d_bc = (v.second > v.third) ? v.second - v.third : v.third - v.second;
		if (d_ab <= d_ac && d_ab <= d_bc)
			sum = v.first + v.second;
		else if (d_ac <= d_bc)
			sum = v.first + v.third;
		else
			sum = v.second + v.third;
		return sum[ADC_W:1];
	endfunction

	// Advance the predicted state by one accepted sample and return its report
	function automatic report_t predict_report(sample_t s);
		report_t            r;
		logic [PRESS_W-1:0] z;
		logic [ADC_W-1:0]   mx, my;
		logic [TIME_W-1:0]  since;
		since = s.now - held_time;
		r.sampled = (since >= TIME_W'(cfg_ival));
		if (r.sampled) begin
			z = PRESS_W'(s.za) + PRESS_W'(FULL_SCALE) - PRESS_W'(s.zb);
			if (z < cfg_thresh) begin
				held_press = '0;
			end else begin
				mx = pair_mean(s.xs);
				my = pair_mean(s.ys);
				held_press = z;
				held_time = s.now;
				case (cfg_orient)
					ORIENT_SWAP_INV_X: begin
						held_x = FULL_SCALE - my;
						held_y = mx;
					end
					ORIENT_IDENTITY: begin
						held_x = mx;
						held_y = my;
					end
					ORIENT_SWAP_INV_Y: begin
						held_x = my;
						held_y = FULL_SCALE - mx;
					end
					default: begin
						held_x = FULL_SCALE - mx;
						held_y = FULL_SCALE - my;
					end
				endcase
			end
		end
		r.touched = (held_press >= cfg_thresh);
		r.pos_x = held_x;
		r.pos_y = held_y;
		r.pressure = held_press;
		return r;
	endfunction

	// Compare one output transaction with the oldest prediction
	function automatic void check_report();
		report_t exp_r;
		if (pending_reports.size() == 0) begin
			$error("result with no prediction waiting");
			fail_count++;
			return;
		end
		exp_r = pending_reports.pop_front();
		if (sampled !== exp_r.sampled) begin
			$error("sampled mismatch: expected %0d, got %0d", exp_r.sampled, sampled);
			fail_count++;
		end
		if (touched !== exp_r.touched) begin
			$error("touched mismatch: expected %0d, got %0d", exp_r.touched, touched);
			fail_count++;
		end
		if (pos_x !== exp_r.pos_x) begin
			$error("pos_x mismatch: expected %0d, got %0d", exp_r.pos_x, pos_x);
			fail_count++;
		end
		if (pos_y !== exp_r.pos_y) begin
			$error("pos_y mismatch: expected %0d, got %0d", exp_r.pos_y, pos_y);
			fail_count++;
		end
		if (pressure !== exp_r.pressure) begin
			$error("pressure mismatch: expected %0d, got %0d", exp_r.pressure, pressure);
			fail_count++;
		end
	endfunction

	// Check results and drive out_ready: random stalls, quiet stretches, long hold
	always @(posedge clk) begin : report_sink
		int unsigned roll;
		if (out_valid && out_ready)
			check_report();
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			stall_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (no_gaps) begin
			out_ready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				out_ready <= 1'b1;
			end else if (roll < 92) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(10, 40);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one sample after a random gap, hold it until accepted, then predict
	task automatic send_sample(input sample_t s);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms   <= s.now;
		press_a  <= s.za;
		press_b  <= s.zb;
		x_first  <= s.xs.first;
		x_second <= s.xs.second;
		x_third  <= s.xs.third;
		y_first  <= s.ys.first;
		y_second <= s.ys.second;
		y_third  <= s.ys.third;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_reports.push_back(predict_report(s));
	endtask

	// Wait until every predicted result has arrived and the block is quiet
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all registers while idle, with junk in unused bits and the spare index
	task automatic apply_config(orient_t o, logic [PRESS_W-1:0] th, logic [IVAL_W-1:0] iv);
		logic [CFG_DATA_W-1:0] junk;
		drain_reports();
		junk = CFG_DATA_W'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ORIENTATION;
		cfg_wdata <= {junk[CFG_DATA_W-1:2], o};
		@(posedge clk);
		cfg_index <= REG_PRESS_THRESH;
		cfg_wdata <= CFG_DATA_W'(th);
		@(posedge clk);
		cfg_index <= REG_MIN_INTERVAL;
		cfg_wdata <= {junk[CFG_DATA_W-1:IVAL_W], iv};
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_orient = o;
		cfg_thresh = th;
		cfg_ival = iv;
	endtask

	function automatic sample_t mk(logic [TIME_W-1:0] t, int za, int zb,
			int x0, int x1, int x2, int y0, int y1, int y2);
		sample_t s;
		s.now = t;
		s.za = ADC_W'(za);
		s.zb = ADC_W'(zb);
		s.xs = '{ADC_W'(x0), ADC_W'(x1), ADC_W'(x2)};
		s.ys = '{ADC_W'(y0), ADC_W'(y1), ADC_W'(y2)};
		return s;
	endfunction

	function automatic int clamp_adc(int v);
		return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
	endfunction

	// Three readings: mostly a close pair plus an outlier, some even spacings
	function automatic axis_set_t make_axis();
		int          v[3];
		int          tmp, base, step;
		int unsigned roll, i, j;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			base = $urandom_range(0, 4095);
			v[0] = clamp_adc(base + $urandom_range(0, 8) - 4);
			v[1] = clamp_adc(base + $urandom_range(0, 8) - 4);
			v[2] = $urandom_range(0, 4095);
		end else if (roll < 85) begin
			step = $urandom_range(0, 1365);
			base = $urandom_range(0, 4095 - 2 * step);
			v[0] = base;
			v[1] = base + step;
			v[2] = base + 2 * step;
		end else begin
			foreach (v[k])
				v[k] = $urandom_range(0, 4095);
		end
		// shuffle the slots
		repeat (2) begin
			i = $urandom_range(0, 2);
			j = $urandom_range(0, 2);
			tmp = v[i];
			v[i] = v[j];
			v[j] = tmp;
		end
		return '{ADC_W'(v[0]), ADC_W'(v[1]), ADC_W'(v[2])};
	endfunction

	// Random sample: time mostly steps near the interval, sometimes jumps or runs back
	function automatic sample_t make_sample();
		sample_t     s;
		int unsigned roll;
		int          target, lo, hi, a;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			clock_ms = clock_ms + $urandom_range(0, int'(cfg_ival) + 3);
		else if (roll < 85)
			clock_ms = clock_ms + $urandom_range(0, 2);
		else if (roll < 93)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms - $urandom_range(1, 1000);
		s.now = clock_ms;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			s.za = ADC_W'($urandom);
			s.zb = ADC_W'($urandom);
		end else begin
			if (roll < 70)
				target = int'(cfg_thresh) + $urandom_range(0, 4) - 2;
			else if (roll < 85)
				target = $urandom_range(6000, 8190);
			else
				target = $urandom_range(0, 800);
			target = (target < 0) ? 0 : (target > 8190) ? 8190 : target;
			lo = (target > 4095) ? target - 4095 : 0;
			hi = (target < 4095) ? target : 4095;
			a = $urandom_range(hi, lo);
			s.za = ADC_W'(a);
			s.zb = ADC_W'(a + 4095 - target);
		end
		s.xs = make_axis();
		s.ys = make_axis();
		return s;
	endfunction

	// Pressure edges and the rate limit, from the reset state
	task automatic test_pressure_and_rate();
		send_sample(mk(32'd0, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095));
		send_sample(mk(32'd2, 2000, 100, 1, 2, 3, 4, 5, 6));
		send_sample(mk(32'd3, 0, 3695, 0, 0, 0, 0, 0, 0));
		send_sample(mk(32'd6, 0, 3696, 900, 901, 902, 903, 904, 905));
		send_sample(mk(32'd7, 0, 4095, 900, 901, 902, 903, 904, 905));
		send_sample(mk(32'd5, 3000, 10, 50, 60, 70, 80, 90, 99));
		send_sample(mk(32'd3, 3000, 10, 50, 60, 70, 80, 90, 99));
		send_sample(mk(32'd2, 2048, 2048, 'hAAA, 'hAAB, 'h555, 'h555, 'h554, 'hAAA));
		send_sample(mk(32'hFFFF_FFFE, 4000, 500, 300, 310, 4000, 1200, 3000, 1201));
		send_sample(mk(32'd0, 4000, 500, 1, 1, 1, 2, 2, 2));
		send_sample(mk(32'd1, 4000, 500, 2222, 2224, 10, 3333, 3331, 4095));
		clock_ms = 32'd100;
	endtask

	// Closest-pair choice, tie order and rounding down of the mean
	task automatic test_pair_selection();
		clock_ms += 3;
		send_sample(mk(clock_ms, 3000, 0, 100, 200, 300, 100, 300, 200));
		clock_ms += 3;
		send_sample(mk(clock_ms, 3000, 0, 0, 4095, 4095, 4095, 0, 4095));
		clock_ms += 3;
		send_sample(mk(clock_ms, 3000, 0, 0, 1, 4095, 4094, 4095, 0));
		clock_ms += 3;
		send_sample(mk(clock_ms, 3000, 0, 10, 20, 15, 2000, 1000, 1500));
		clock_ms += 3;
		send_sample(mk(clock_ms, 3000, 0, 7, 7, 7, 4000, 9, 11));
	endtask

	// One touch per panel rotation
	task automatic test_orientation();
		orient_t o;
		for (int k = 0; k < 4; k++) begin
			o = orient_t'(k);
			apply_config(o, RST_PRESS_THRESH, RST_MIN_INTERVAL);
			clock_ms += 3;
			send_sample(mk(clock_ms, 3500, 200, 1000, 1003, 3000, 123, 4000, 125));
		end
	endtask

	// Threshold and interval extremes
	task automatic test_thresholds();
		apply_config(ORIENT_IDENTITY, '0, '0);
		send_sample(mk(clock_ms, 0, 4095, 10, 11, 12, 20, 21, 22));
		send_sample(mk(clock_ms, 0, 4095, 30, 31, 32, 40, 41, 42));
		apply_config(ORIENT_IDENTITY, 13'd8190, 8'd255);
		clock_ms += 255;
		send_sample(mk(clock_ms, 4095, 0, 500, 501, 502, 600, 601, 602));
		clock_ms += 254;
		send_sample(mk(clock_ms, 4095, 0, 700, 701, 702, 800, 801, 802));
		clock_ms += 1;
		send_sample(mk(clock_ms, 4095, 1, 900, 901, 902, 950, 951, 952));
		apply_config(ORIENT_INV_BOTH, 13'd8191, 8'd1);
		clock_ms += 1;
		send_sample(mk(clock_ms, 4095, 0, 1500, 1501, 1502, 1600, 1601, 1602));
	endtask

	// Receiver holds off long while the sender keeps offering: input must stall
	task automatic test_backpressure();
		apply_config(ORIENT_SWAP_INV_Y, RST_PRESS_THRESH, 8'd2);
		no_gaps <= 1'b1;
		hold_reqs <= hold_reqs + 1;
		repeat (30)
			send_sample(make_sample());
		no_gaps <= 1'b0;
	endtask

	// Random traffic over extreme and random register settings
	task automatic test_random_traffic();
		orient_t            o;
		logic [PRESS_W-1:0] th;
		logic [IVAL_W-1:0]  iv;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					o = ORIENT_SWAP_INV_X;
					th = '0;
					iv = '0;
				end
				1: begin
					o = ORIENT_INV_BOTH;
					th = 13'd8190;
					iv = 8'd255;
				end
				2: begin
					o = ORIENT_SWAP_INV_Y;
					th = 13'd8191;
					iv = 8'd1;
				end
				3: begin
					o = RST_ORIENTATION;
					th = RST_PRESS_THRESH;
					iv = RST_MIN_INTERVAL;
				end
				default: begin
					o = orient_t'($urandom_range(0, 3));
					th = PRESS_W'($urandom_range(0, 8190));
					iv = ($urandom_range(0, 9) == 0) ? 8'd255 : IVAL_W'($urandom_range(0, 12));
				end
			endcase
			apply_config(o, th, iv);
			// one phase runs with no idling on either side
			no_gaps <= (p == 5);
			repeat (PHASE_ITEMS)
				send_sample(make_sample());
		end
		no_gaps <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pressure_and_rate();
		test_pair_selection();
		test_orientation();
		test_thresholds();
		test_backpressure();
		test_random_traffic();
		drain_reports();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
